// ----- design/lrup_pkg.sv -----
// Shared constants, types and state codes for the LRU page replacement block.
package lrup_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;

  // Fixed field widths of the streams and the register
  localparam int PAGE_IO_W  = 16;
  localparam int FIDX_IO_W  = 3;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  localparam int AGE_W  = 4;
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // Search record rippled along the row of frame cells
  typedef struct packed {
    logic                 hit_found;
    logic [FIDX_W-1:0]    hit_idx;
    logic [AGE_W-1:0]     hit_age;
    logic                 empty_found;
    logic [FIDX_W-1:0]    empty_idx;
    logic                 old_found;
    logic [FIDX_W-1:0]    old_idx;
    logic [AGE_W-1:0]     old_age;
    logic [PAGE_BITS-1:0] old_page;
  } scan_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                 en;
    logic                 hit;
    logic [FIDX_W-1:0]    idx;
    logic [AGE_W-1:0]     ref_age;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

endpackage

// ----- design/lru_page_replacement.sv -----
// Top level: LRU page replacement over a row of frame cells.
// Usage:
//   in_*  : one page reference per item, page_number in in_tdata[15:0].
//   out_* : one result per reference: hit, frame holding the page, any evicted
//           page and the running fault count (saturates at all ones).
//   cfg_* : write of frames_in_use; 0 acts as 1, above 8 acts as 8. Write only
//           while no reference is in flight; cfg_ready is always high.
// Operation: a reference is taken in IDLE, searched as the scan ripples along the
//   frame cells in SEARCH, and written into the cells in UPDATE, which also loads
//   the output register; the next reference is taken only back in IDLE.
// A result waits in the output register while the receiver stalls; the next
//   reference is still taken and searched, and its update waits until the
//   output register frees. No stall is needed on an idle receiver.
// Reset (rst, synchronous): all frames empty, ages and fault count cleared,
//   frames_in_use back to 8. No clearing pass is needed.
module lru_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lrup_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] page_number
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hit, [3:1] frame_index, [4] evicted_valid, [20:5] evicted_page,
  // [52:21] fault_count, [55:53] zero
  output logic [lrup_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrup_pkg::CFG_W-1:0]      cfg_data     // frames_in_use
);

  lrup_pkg::state_t state, state_next;

  logic [lrup_pkg::CFG_W-1:0]     frames_in_use;
  logic [lrup_pkg::CNT_W-1:0]     active_n;
  logic [lrup_pkg::FRAMES-1:0]    active;
  logic [lrup_pkg::PAGE_BITS-1:0] req_page;
  logic [lrup_pkg::FAULT_W-1:0]   faults;

  logic                           dec_hit;
  logic [lrup_pkg::FIDX_W-1:0]    dec_idx;
  logic [lrup_pkg::AGE_W-1:0]     dec_age;
  logic                           dec_ev_valid;
  logic [lrup_pkg::PAGE_BITS-1:0] dec_ev_page;

  lrup_pkg::scan_t chain [lrup_pkg::FRAMES+1];
  lrup_pkg::upd_t  upd;
  logic            upd_en;
  logic            in_accept;
  logic            out_free;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrup_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      active_n = lrup_pkg::CNT_W'(1);
    end else if (int'(frames_in_use) > lrup_pkg::FRAMES) begin
      active_n = lrup_pkg::CNT_W'(lrup_pkg::FRAMES);
    end else begin
      active_n = lrup_pkg::CNT_W'(frames_in_use);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < lrup_pkg::FRAMES; i++) begin : g_cell
    assign active[i] = (i < int'(active_n));
    lrup_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (lrup_pkg::FIDX_W'(i)),
      .active   (active[i]),
      .ref_page (req_page),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .upd      (upd)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrup_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_tready  = 1'b0;
    upd_en     = 1'b0;
    case (state)
      lrup_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_next = lrup_pkg::ST_SEARCH;
        end
      end
      lrup_pkg::ST_SEARCH: begin
        state_next = lrup_pkg::ST_UPDATE;
      end
      lrup_pkg::ST_UPDATE: begin
        if (out_free) begin
          upd_en     = 1'b1;
          state_next = lrup_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrup_pkg::ST_IDLE;
      end
    endcase
  end

  assign upd = '{en: upd_en, hit: dec_hit, idx: dec_idx, ref_age: dec_age,
                 page: req_page};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_page <= lrup_pkg::PAGE_BITS'(in_tdata[lrup_pkg::PAGE_IO_W-1:0]);
    end
  end

  // Decision taken from the far end of the chain
  always_ff @(posedge clk) begin
    if (state == lrup_pkg::ST_SEARCH) begin
      dec_hit      <= chain[lrup_pkg::FRAMES].hit_found;
      dec_age      <= chain[lrup_pkg::FRAMES].hit_age;
      dec_ev_valid <= !chain[lrup_pkg::FRAMES].hit_found &&
                      !chain[lrup_pkg::FRAMES].empty_found;
      dec_ev_page  <= chain[lrup_pkg::FRAMES].old_page;
      if (chain[lrup_pkg::FRAMES].hit_found) begin
        dec_idx <= chain[lrup_pkg::FRAMES].hit_idx;
      end else if (chain[lrup_pkg::FRAMES].empty_found) begin
        dec_idx <= chain[lrup_pkg::FRAMES].empty_idx;
      end else begin
        dec_idx <= chain[lrup_pkg::FRAMES].old_idx;
      end
    end
  end

  logic [lrup_pkg::FAULT_W-1:0] faults_next;

  assign faults_next = (!dec_hit && faults != lrup_pkg::FAULT_MAX) ?
                       faults + lrup_pkg::FAULT_W'(1) : faults;

  always_ff @(posedge clk) begin
    if (rst) begin
      faults     <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (upd_en) begin
        faults     <= faults_next;
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_tdata <= {3'b000,
                    faults_next,
                    dec_ev_valid ? lrup_pkg::PAGE_IO_W'(dec_ev_page) :
                                   lrup_pkg::PAGE_IO_W'(0),
                    dec_ev_valid,
                    lrup_pkg::FIDX_IO_W'(dec_idx),
                    dec_hit};
    end
  end

  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> faults >= $past(faults))
    else $error("fault count went backwards");

  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    upd.en |=> out_tvalid && state == lrup_pkg::ST_IDLE)
    else $error("update did not deliver a result");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (upd.en && upd.hit) |=> !out_tdata[4] && out_tdata[0])
    else $error("hit reported an eviction");

endmodule

// ----- design/lrup_cell.sv -----
// One page frame: page, valid mark and age, with its link of the search chain.
module lrup_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lrup_pkg::FIDX_W-1:0]    idx,
  input  logic                           active,
  input  logic [lrup_pkg::PAGE_BITS-1:0] ref_page,
  input  lrup_pkg::scan_t                scan_in,
  output lrup_pkg::scan_t                scan_out,
  input  lrup_pkg::upd_t                 upd
);

  logic [lrup_pkg::PAGE_BITS-1:0] page;
  logic                           valid;
  logic [lrup_pkg::AGE_W-1:0]     age;
  logic [lrup_pkg::AGE_W-1:0]     age_inc;

  assign age_inc = (age != lrup_pkg::AGE_MAX) ? age + lrup_pkg::AGE_W'(1) : age;

  always_comb begin
    scan_out = scan_in;
    if (active && valid && page == ref_page && !scan_in.hit_found) begin
      scan_out.hit_found = 1'b1;
      scan_out.hit_idx   = idx;
      scan_out.hit_age   = age;
    end
    if (active && !valid && !scan_in.empty_found) begin
      scan_out.empty_found = 1'b1;
      scan_out.empty_idx   = idx;
    end
    // strict compare keeps the lowest frame on tied ages
    if (active && (!scan_in.old_found || age > scan_in.old_age)) begin
      scan_out.old_found = 1'b1;
      scan_out.old_idx   = idx;
      scan_out.old_age   = age;
      scan_out.old_page  = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (upd.en && active) begin
      if (upd.idx == idx) begin
        valid <= 1'b1;
        age   <= '0;
      end else if (valid && (!upd.hit || age < upd.ref_age)) begin
        age <= age_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && active && upd.idx == idx && !upd.hit) begin
      page <= upd.page;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for lru_page_replacement: random traffic, own LRU predictor, stalls.
module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 95;

  // Result item as laid out on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] fault_count;
    logic [15:0] evicted_page;
    logic        evicted_valid;
    logic [2:0]  frame_index;
    logic        hit;
  } lru_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lrup_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lrup_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrup_pkg::CFG_W-1:0] cfg_data = '0;

  lru_page_replacement dut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [15:0]                res_page [lrup_pkg::FRAMES];
  logic                       res_valid[lrup_pkg::FRAMES];
  logic [lrup_pkg::AGE_W-1:0] res_age  [lrup_pkg::FRAMES];
  logic [31:0]                faults;
  logic [lrup_pkg::CFG_W-1:0] frames_cfg;

  logic [15:0] page_q[$];
  lru_result_t predicted[$];
  int bad_results = 0;

  // Stimulus shaping; the phase settings are written by the sequencer at the falling edge
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int in_gap = 0;
  int ready_gap = 0;
  logic [15:0] hot_pages[12];
  int hot_count = 8;
  logic [15:0] last_page = '0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [15:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) last_page = hot_pages[$urandom_range(0, hot_count - 1)];
    else if (r >= 90) last_page = 16'($urandom_range(0, 16'hFFFF));
    return last_page;
  endfunction

  // One reference through the LRU frame set; updates predictor state
  function automatic lru_result_t reference_page(logic [15:0] pg);
    lru_result_t r;
    int n;
    int sel;
    bit found;
    bit empty;
    logic [lrup_pkg::AGE_W-1:0] a;
    logic [lrup_pkg::AGE_W-1:0] oldest;
    r = '0;
    found = 1'b0;
    empty = 1'b0;
    sel = 0;
    n = (frames_cfg == 0) ? 1 :
        (frames_cfg > lrup_pkg::FRAMES) ? lrup_pkg::FRAMES : int'(frames_cfg);
    for (int i = 0; i < n; i++)
      if (!found && res_valid[i] && res_page[i] == pg) begin
        found = 1'b1;
        sel = i;
      end
    if (found) begin
      a = res_age[sel];
      for (int i = 0; i < n; i++)
        if (i != sel && res_valid[i] && res_age[i] < a &&
            res_age[i] != lrup_pkg::AGE_MAX)
          res_age[i]++;
    end else begin
      for (int i = 0; i < n; i++)
        if (!empty && !res_valid[i]) begin
          empty = 1'b1;
          sel = i;
        end
      if (!empty) begin
        // oldest wins, lowest frame on a tie
        oldest = '0;
        sel = 0;
        for (int i = 0; i < n; i++)
          if (res_age[i] > oldest) begin
            oldest = res_age[i];
            sel = i;
          end
        r.evicted_valid = 1'b1;
        r.evicted_page = res_page[sel];
      end
      for (int i = 0; i < n; i++)
        if (i != sel && res_valid[i] && res_age[i] != lrup_pkg::AGE_MAX)
          res_age[i]++;
      res_page[sel] = pg;
      res_valid[sel] = 1'b1;
      if (faults != lrup_pkg::FAULT_MAX) faults++;
    end
    res_age[sel] = '0;
    r.hit = found;
    r.frame_index = sel[2:0];
    r.fault_count = faults;
    return r;
  endfunction

  // Driver: page references from page_q
  always @(posedge clk) begin
    if (rst) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (page_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= page_q.pop_front();
        in_gap = in_steady ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with the long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      out_tready <= 1'b0;
      ready_gap--;
    end else begin
      out_tready <= 1'b1;
      ready_gap = out_steady ? 0 : pick_gap();
    end
  end

  // Monitor: predicts on accepted references, checks accepted results
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (rst) begin
      for (int i = 0; i < lrup_pkg::FRAMES; i++) begin
        res_page[i] = '0;
        res_valid[i] = 1'b0;
        res_age[i] = '0;
      end
      faults = '0;
      frames_cfg = lrup_pkg::CFG_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        got = lru_result_t'(out_tdata);
        if (predicted.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result item: %h", out_tdata);
        end else begin
          want = predicted.pop_front();
          if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_page !== want.evicted_page ||
              got.fault_count !== want.fault_count || got.pad !== want.pad) begin
            bad_results++;
            if (bad_results <= 10)
              $display({"mismatch: want hit=%b frame=%0d ev=%b page=%h faults=%0d pad=%b",
                        " | got hit=%b frame=%0d ev=%b page=%h faults=%0d pad=%b"},
                       want.hit, want.frame_index, want.evicted_valid, want.evicted_page,
                       want.fault_count, want.pad, got.hit, got.frame_index,
                       got.evicted_valid, got.evicted_page, got.fault_count, got.pad);
          end
        end
      end
      if (cfg_valid && cfg_ready) frames_cfg = cfg_data;
      if (in_tvalid && in_tready) predicted.push_back(reference_page(in_tdata));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (page_q.size() != 0 || in_tvalid || predicted.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frames(logic [lrup_pkg::CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sequencer
    logic [15:0] opening[12];
    int frame_plan[12];
    int n;
    opening = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF,
                16'h5555, 16'hAAAA, 16'h1234, 16'hFFFF, 16'h4321, 16'h00FF};
    frame_plan = '{8, 1, 3, 9, 5, 2, 7, 4, 6, 15, 0, 8};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill from empty, hits, eviction after full, then odd frame counts
    @(negedge clk);
    foreach (opening[i]) page_q.push_back(opening[i]);
    set_frames(4'd0);          // acts as one frame
    @(negedge clk);
    page_q.push_back(16'h0F0F);
    page_q.push_back(16'h0F0F);
    page_q.push_back(16'hF0F0);
    set_frames(4'd15);         // clipped to all frames
    @(negedge clk);
    page_q.push_back(16'h5555);
    page_q.push_back(16'h0001);
    page_q.push_back(16'h9999);
    set_frames(4'd2);          // frames above 1 keep their pages but never match
    @(negedge clk);
    page_q.push_back(16'h7FFF);
    page_q.push_back(16'h1234);
    page_q.push_back(16'h7FFF);
    set_frames(4'd8);
    @(negedge clk);
    page_q.push_back(16'hAAAA);
    page_q.push_back(16'h4321);
    page_q.push_back(16'h0000);

    // Random phases: working set as large as the active frames or up to four pages larger
    foreach (frame_plan[ph]) begin
      set_frames(frame_plan[ph][lrup_pkg::CFG_W-1:0]);
      @(negedge clk);
      n = (frame_plan[ph] < 1) ? 1 :
          (frame_plan[ph] > lrup_pkg::FRAMES) ? lrup_pkg::FRAMES : frame_plan[ph];
      hot_count = n + $urandom_range(0, 4);
      foreach (hot_pages[i]) hot_pages[i] = 16'($urandom_range(0, 16'hFFFF));
      in_steady = (ph % 4 == 1) || (ph == 7);
      out_steady = (ph % 3 == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) page_q.push_back(pick_page());
      if (ph == 2 || ph == 7) holds_asked++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && predicted.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
